@@ hw/rtl/multi_keyword_stream_matcher_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the keyword stream matcher
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MULTI_KEYWORD_STREAM_MATCHER_UNIT_ASSERT_SVH
`define MULTI_KEYWORD_STREAM_MATCHER_UNIT_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent
`define MKSM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent
`define MKSM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/mksm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mksm_pkg
// Shared types and constants of the keyword stream matcher.
// ----------------------------------------------------------------------------
package mksm_pkg;

    localparam logic [7:0]  WILDCARD_CHAR     = 8'h09;
    localparam logic [7:0]  END_CHAR          = 8'h00;
    localparam logic [15:0] PAYLOAD_LIMIT_RST = 16'd256;
    localparam logic [31:0] IDLE_TIMEOUT_RST  = 32'd10000;

    localparam logic CMD_STREAM      = 1'b0;
    localparam logic CMD_TABLE_WRITE = 1'b1;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_MATCH   = 2'd1,
        EV_PAYLOAD = 2'd2
    } event_t;

    typedef enum logic [1:0] {
        CFG_ACTIVE_PATTERNS = 2'd0,
        CFG_PAYLOAD_LIMIT   = 2'd1,
        CFG_IDLE_TIMEOUT    = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRE,
        ST_READ,
        ST_EVAL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic latch;
        logic pre;
        logic eval;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic item_cmd;
        logic payload_step;
        logic no_keywords;
        logic last_keyword;
        logic out_free;
    } dp_status_t;

    typedef struct packed {
        event_t      ev;
        logic [2:0]  keyword_id;
        logic [15:0] index;
        logic [7:0]  data;
        logic        last;
        logic        timed;
    } result_t;

endpackage

@@ hw/rtl/mksm_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mksm_in_if / mksm_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface mksm_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [7:0]  char_value;
    logic [31:0] time_ms;
    logic        consumer_stop;
    logic [2:0]  write_pattern;
    logic [3:0]  write_position;

    modport source (
        output valid, cmd, char_value, time_ms, consumer_stop, write_pattern,
               write_position,
        input  ready
    );

    modport sink (
        input  valid, cmd, char_value, time_ms, consumer_stop, write_pattern,
               write_position,
        output ready
    );
endinterface

interface mksm_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_res;
    logic [2:0]  keyword_id;
    logic [15:0] payload_index;
    logic [7:0]  payload_byte;
    logic        payload_last;
    logic        timed_out;

    modport source (
        output valid, event_res, keyword_id, payload_index, payload_byte,
               payload_last, timed_out,
        input  ready
    );

    modport sink (
        input  valid, event_res, keyword_id, payload_index, payload_byte,
               payload_last, timed_out,
        output ready
    );
endinterface

@@ hw/rtl/mksm_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mksm_ram
// Generic RAM: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module mksm_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 128,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr_a,
    input  logic [ADDR_W-1:0] raddr_b,
    output logic [WIDTH-1:0]  rdata_a,
    output logic [WIDTH-1:0]  rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_a_reg <= mem_reg[raddr_a];
        rdata_b_reg <= mem_reg[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

@@ hw/rtl/mksm_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mksm_ctrl
// Sequencer: takes an item, walks the keywords, hands the result over.
// ----------------------------------------------------------------------------
`include "multi_keyword_stream_matcher_unit_assert.svh"

module mksm_ctrl
    import mksm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  dp_status_t sts,
    output dp_cmd_t    ctl
);

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = ST_PRE;
                end
            end
            ST_PRE:
            begin
                if (sts.item_cmd || sts.payload_step || sts.no_keywords)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                state_next = sts.last_keyword ? ST_DONE : ST_READ;
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_ready   = 1'b0;
        ctl          = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                ctl.latch  = item_valid;
            end
            ST_PRE:
            begin
                ctl.pre = 1'b1;
            end
            ST_READ:
            begin
            end
            ST_EVAL:
            begin
                ctl.eval = 1'b1;
            end
            ST_DONE:
            begin
                ctl.load_out = sts.out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `MKSM_ASSERT_NXT(a_read_then_eval, state_reg == ST_READ, state_reg == ST_EVAL, "read not followed by evaluate")
    `MKSM_ASSERT_NXT(a_done_to_idle, state_reg == ST_DONE && sts.out_free, state_reg == ST_IDLE, "result handed over but not idle")

endmodule

@@ hw/rtl/mksm_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mksm_dp
// Datapath: keyword table, progress counts, payload phase and result register.
// ----------------------------------------------------------------------------
`include "multi_keyword_stream_matcher_unit_assert.svh"

module mksm_dp
    import mksm_pkg::*;
#(
    parameter int NUM_PATTERNS    = 8,
    parameter int MAX_PATTERN_LEN = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     ctl,
    output dp_status_t  sts,
    input  logic        cmd,
    input  logic [7:0]  char_value,
    input  logic [31:0] time_ms,
    input  logic        consumer_stop,
    input  logic [2:0]  write_pattern,
    input  logic [3:0]  write_position,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [1:0]  event_res,
    output logic [2:0]  keyword_id,
    output logic [15:0] payload_index,
    output logic [7:0]  payload_byte,
    output logic        payload_last,
    output logic        timed_out
);

    localparam int KW_W   = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
    localparam int CNT_W  = $clog2(NUM_PATTERNS + 1);
    localparam int P_W    = $clog2(MAX_PATTERN_LEN + 1);
    localparam int DEPTH  = NUM_PATTERNS * MAX_PATTERN_LEN;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [P_W-1:0] P_MAX = P_W'(MAX_PATTERN_LEN);

    // item held for the duration of its processing
    logic        cmd_reg;
    logic [7:0]  char_reg;
    logic [31:0] time_reg;
    logic        stop_reg;
    logic [2:0]  wpat_reg;
    logic [3:0]  wpos_reg;
    logic        cmd_next;
    logic [7:0]  char_next;
    logic [31:0] time_next;
    logic        stop_next;
    logic [2:0]  wpat_next;
    logic [3:0]  wpos_next;

    logic [3:0]  active_reg;
    logic [15:0] limit_reg;
    logic [31:0] timeout_reg;
    logic [3:0]  active_next;
    logic [15:0] limit_next;
    logic [31:0] timeout_next;

    logic [P_W-1:0] progress_reg [NUM_PATTERNS];
    logic [P_W-1:0] progress_next [NUM_PATTERNS];
    logic [7:0]     first_reg [NUM_PATTERNS];
    logic [7:0]     first_next [NUM_PATTERNS];

    logic [7:0]      lac_reg;
    logic            in_payload_reg;
    logic [KW_W-1:0] cur_reg;
    logic [15:0]     count_reg;
    logic [31:0]     start_reg;
    logic [KW_W-1:0] k_reg;
    logic [7:0]      lac_next;
    logic            in_payload_next;
    logic [KW_W-1:0] cur_next;
    logic [15:0]     count_next;
    logic [31:0]     start_next;
    logic [KW_W-1:0] k_next;

    result_t res_reg;
    result_t res_next;
    result_t out_reg;
    result_t out_next;
    logic    out_valid_reg;
    logic    out_valid_next;

    logic [CNT_W-1:0]  n_active;
    logic [31:0]       elapsed;
    logic              timeout_hit;
    logic              payload_step;
    logic [15:0]       count_inc;
    logic              phase_end;
    logic [P_W-1:0]    p_cur;
    logic [P_W-1:0]    p_inc;
    logic [7:0]        first_cur;
    logic              at_end;
    logic [7:0]        ch_cur;
    logic              char_hit;
    logic              next_end;
    logic              wr_ok;
    logic              ram_we;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] row_base;
    logic [ADDR_W-1:0] raddr_a;
    logic [ADDR_W-1:0] raddr_b;
    logic [7:0]        rd_a;
    logic [7:0]        rd_b;

    mksm_ram #(
        .WIDTH  (8),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_table (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (waddr),
        .wdata   (char_reg),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    always_comb
    begin
        if (int'(active_reg) > NUM_PATTERNS)
        begin
            n_active = CNT_W'(NUM_PATTERNS);
        end
        else
        begin
            n_active = CNT_W'(active_reg);
        end
    end

    // wrapping distance from phase entry
    assign elapsed      = time_reg - start_reg;
    assign timeout_hit  = in_payload_reg && (elapsed >= timeout_reg);
    assign payload_step = in_payload_reg && !timeout_hit;
    assign count_inc    = count_reg + 16'd1;
    assign phase_end    = stop_reg || (count_inc >= limit_reg);

    // table write
    assign wr_ok  = (int'(wpat_reg) < NUM_PATTERNS) && (int'(wpos_reg) < MAX_PATTERN_LEN);
    assign ram_we = ctl.pre && (cmd_reg == CMD_TABLE_WRITE) && wr_ok;
    assign waddr  = ADDR_W'(wpat_reg) * ADDR_W'(MAX_PATTERN_LEN) + ADDR_W'(wpos_reg);

    // current keyword: its expected char and the one after it
    assign p_cur     = progress_reg[k_reg];
    assign first_cur = first_reg[k_reg];
    assign at_end    = (p_cur == P_MAX);
    assign p_inc     = at_end ? P_MAX : (p_cur + P_W'(1));
    assign row_base  = ADDR_W'(k_reg) * ADDR_W'(MAX_PATTERN_LEN);
    assign raddr_a   = row_base + ADDR_W'(p_cur);
    assign raddr_b   = row_base + ADDR_W'(p_inc);
    // past the last position the table reads as the terminator
    assign ch_cur    = at_end ? END_CHAR : rd_a;
    assign char_hit  = (char_reg == ch_cur) || (ch_cur == WILDCARD_CHAR);
    assign next_end  = (p_inc == P_MAX) || (rd_b == END_CHAR);

    assign sts.item_cmd     = (cmd_reg == CMD_TABLE_WRITE);
    assign sts.payload_step = payload_step;
    assign sts.no_keywords  = (n_active == '0);
    assign sts.last_keyword = ((CNT_W'(k_reg) + CNT_W'(1)) == n_active);
    assign sts.out_free     = !out_valid_reg || result_ready;

    always_comb
    begin
        cmd_next        = cmd_reg;
        char_next       = char_reg;
        time_next       = time_reg;
        stop_next       = stop_reg;
        wpat_next       = wpat_reg;
        wpos_next       = wpos_reg;
        active_next     = active_reg;
        limit_next      = limit_reg;
        timeout_next    = timeout_reg;
        progress_next   = progress_reg;
        first_next      = first_reg;
        lac_next        = lac_reg;
        in_payload_next = in_payload_reg;
        cur_next        = cur_reg;
        count_next      = count_reg;
        start_next      = start_reg;
        k_next          = k_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;

        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_ACTIVE_PATTERNS: active_next  = cfg_data[3:0];
                CFG_PAYLOAD_LIMIT:   limit_next   = cfg_data[15:0];
                CFG_IDLE_TIMEOUT:    timeout_next = cfg_data;
                default:
                begin
                end
            endcase
        end

        if (ctl.latch)
        begin
            cmd_next  = cmd;
            char_next = char_value;
            time_next = time_ms;
            stop_next = consumer_stop;
            wpat_next = write_pattern;
            wpos_next = write_position;
        end

        if (ctl.pre)
        begin
            k_next   = '0;
            res_next = '0;
            if (cmd_reg == CMD_TABLE_WRITE)
            begin
                // keep a copy of each first char for the mismatch restart
                if (wr_ok && (wpos_reg == 4'd0))
                begin
                    first_next[KW_W'(wpat_reg)] = char_reg;
                end
            end
            else
            begin
                if (!in_payload_reg)
                begin
                    start_next = time_reg;
                end
                else if (timeout_hit)
                begin
                    // abandon the phase, then match this byte normally
                    start_next      = time_reg;
                    in_payload_next = 1'b0;
                    res_next.timed  = 1'b1;
                    for (int i = 0; i < NUM_PATTERNS; i++)
                    begin
                        if (i < int'(n_active))
                        begin
                            progress_next[i] = '0;
                        end
                    end
                end

                if (payload_step)
                begin
                    res_next.ev         = EV_PAYLOAD;
                    res_next.keyword_id = 3'(cur_reg);
                    res_next.index      = count_reg;
                    res_next.data       = char_reg;
                    res_next.last       = phase_end;
                    count_next          = count_inc;
                    if (phase_end)
                    begin
                        in_payload_next = 1'b0;
                        for (int i = 0; i < NUM_PATTERNS; i++)
                        begin
                            if (i < int'(n_active))
                            begin
                                progress_next[i] = '0;
                            end
                        end
                    end
                end
            end
        end

        if (ctl.eval)
        begin
            k_next = k_reg + KW_W'(1);
            if (char_hit)
            begin
                lac_next             = char_reg;
                progress_next[k_reg] = p_inc;
                if (next_end)
                begin
                    // later keywords overwrite, so the highest index wins
                    cur_next            = k_reg;
                    in_payload_next     = 1'b1;
                    count_next          = '0;
                    res_next.ev         = EV_MATCH;
                    res_next.keyword_id = 3'(k_reg);
                end
            end
            else if (lac_reg == first_cur)
            begin
                progress_next[k_reg] = P_W'(1);
            end
            else
            begin
                progress_next[k_reg] = '0;
            end
        end

        if (ctl.load_out)
        begin
            out_valid_next = 1'b1;
            out_next       = res_reg;
        end
        else if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 4'd0;
            limit_reg      <= PAYLOAD_LIMIT_RST;
            timeout_reg    <= IDLE_TIMEOUT_RST;
            progress_reg   <= '{default: '0};
            lac_reg        <= 8'd0;
            in_payload_reg <= 1'b0;
            cur_reg        <= '0;
            count_reg      <= 16'd0;
            start_reg      <= 32'd0;
            k_reg          <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            active_reg     <= active_next;
            limit_reg      <= limit_next;
            timeout_reg    <= timeout_next;
            progress_reg   <= progress_next;
            lac_reg        <= lac_next;
            in_payload_reg <= in_payload_next;
            cur_reg        <= cur_next;
            count_reg      <= count_next;
            start_reg      <= start_next;
            k_reg          <= k_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        char_reg  <= char_next;
        time_reg  <= time_next;
        stop_reg  <= stop_next;
        wpat_reg  <= wpat_next;
        wpos_reg  <= wpos_next;
        first_reg <= first_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
    end

    assign result_valid  = out_valid_reg;
    assign event_res     = out_reg.ev;
    assign keyword_id    = out_reg.keyword_id;
    assign payload_index = out_reg.index;
    assign payload_byte  = out_reg.data;
    assign payload_last  = out_reg.last;
    assign timed_out     = out_reg.timed;

    `MKSM_ASSERT_NXT(a_phase_start, ctl.pre && cmd_reg == CMD_STREAM && !in_payload_reg, start_reg == $past(time_reg), "phase start not taken from byte")
    `MKSM_ASSERT_NXT(a_match_enters_payload, ctl.eval && char_hit && next_end, in_payload_reg, "completed keyword did not start payload")
    `MKSM_ASSERT_IMP(a_payload_not_timed, out_valid_reg && out_reg.ev == EV_PAYLOAD, !out_reg.timed, "payload byte flagged as timed out")

endmodule

@@ hw/rtl/multi_keyword_stream_matcher_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_keyword_stream_matcher_unit
// Matches a byte stream against loaded keywords and passes on the payload.
// ----------------------------------------------------------------------------
// One item is taken at a time. A table write or a payload byte passes through
// the IDLE, PRE and DONE states; a stream byte outside the payload phase also
// visits N = min(active_patterns, NUM_PATTERNS) keywords one after another
// through the shared keyword table RAM, in a READ state and an EVAL state each.
// The result sits in an output register, so a new item is taken while the
// previous result waits. No clearing pass after reset; reading a keyword
// position that was never written gives undefined results.
// ----------------------------------------------------------------------------
module multi_keyword_stream_matcher_unit
    import mksm_pkg::*;
#(
    parameter int NUM_PATTERNS    = 8,
    parameter int MAX_PATTERN_LEN = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    mksm_in_if.sink     stream,
    mksm_out_if.source  result,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    dp_cmd_t    ctl;
    dp_status_t sts;
    logic       item_ready;

    assign stream.ready = item_ready;

    mksm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (stream.valid),
        .item_ready (item_ready),
        .sts        (sts),
        .ctl        (ctl)
    );

    mksm_dp #(
        .NUM_PATTERNS    (NUM_PATTERNS),
        .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .sts            (sts),
        .cmd            (stream.cmd),
        .char_value     (stream.char_value),
        .time_ms        (stream.time_ms),
        .consumer_stop  (stream.consumer_stop),
        .write_pattern  (stream.write_pattern),
        .write_position (stream.write_position),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .result_valid   (result.valid),
        .result_ready   (result.ready),
        .event_res      (result.event_res),
        .keyword_id     (result.keyword_id),
        .payload_index  (result.payload_index),
        .payload_byte   (result.payload_byte),
        .payload_last   (result.payload_last),
        .timed_out      (result.timed_out)
    );

endmodule
